// ===== hw/rtl/bnr_pkg.sv =====
// shared types and constants for the blocked node reachability block
`default_nettype none
package bnr_pkg;
  localparam int NODE_W = 11;
  localparam int IDX_W  = 14;
  localparam int VAL_W  = 14;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;
  localparam int HI_W   = 15;

  localparam logic [FUNC_W-1:0] FN_ROW   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_EDGE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_BLK   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RUN   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_START = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic init_sweep;
    logic run_sweep;
    logic accept;
    logic emit_imm;
    logic emit_qry;
    logic emit_run;
    logic run_go;
    logic seed;
    logic pop;
    logic row_lo;
    logic row_hi;
    logic row_end;
    logic edge_rd;
    logic tgt_rd;
    logic visit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sweep_last;
    logic run_ok;
    logic qry_ok;
    logic q_empty;
    logic e_done;
    logic t_ok;
    logic t_free;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bnr_if.sv =====
// input and result channel interfaces
`default_nettype none
interface bnr_in_if;
  logic                      valid;
  logic                      ready;
  logic [bnr_pkg::FUNC_W-1:0] func;
  logic [bnr_pkg::IDX_W-1:0]  index;
  logic [bnr_pkg::VAL_W-1:0]  value;
  modport source (output valid, output func, output index, output value, input ready);
  modport sink (input valid, input func, input index, input value, output ready);
endinterface

interface bnr_out_if;
  logic                       valid;
  logic                       ready;
  logic [bnr_pkg::STAT_W-1:0] status;
  logic [bnr_pkg::NODE_W-1:0] reached_count;
  logic                       start_was_blocked;
  logic                       node_reached;
  modport source (output valid, output status, output reached_count,
                  output start_was_blocked, output node_reached, input ready);
  modport sink (input valid, input status, input reached_count,
                input start_was_blocked, input node_reached, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/blocked_node_reachability.sv =====
// Breadth-first reachability over a directed graph held in compressed-row form, with
// blocked nodes other than the start never entered. Every item waits for a free result
// slot. A run item first clears the reached map, then for each visited node reads its row
// bounds and scans its edges, checking each target that lies in range. After reset a
// pass clears the blocked and reached maps; no item is taken during it. node_count is
// written over the APB-style port at any byte address with bit 2 clear (0 to 3).
`default_nettype none
module blocked_node_reachability #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 8192
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bnr_in_if.sink           in_ch,
  bnr_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int NW = bnr_pkg::NODE_W;

  bnr_pkg::cmd_t   cmd;
  bnr_pkg::sts_t   sts;
  logic [NW-1:0]   node_count_r, node_count_nxt, wr_val;
  logic            cfg_wr;

  // node count register with clamping
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign wr_val     = cfg_pwdata[NW-1:0];
  always_comb begin
    if (wr_val == '0) begin
      node_count_nxt = NW'(1);
    end else if (32'(wr_val) > MAX_NODES) begin
      node_count_nxt = NW'(MAX_NODES);
    end else begin
      node_count_nxt = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NW'(MAX_NODES);
    end else if (cfg_wr) begin
      node_count_r <= node_count_nxt;
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(node_count_r);

  bnr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .sts, .cmd
  );

  bnr_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst_n, .cmd, .sts, .node_count(node_count_r),
    .in_func(in_ch.func), .in_index(in_ch.index), .in_value(in_ch.value),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_status(out_ch.status),
    .out_reached_count(out_ch.reached_count),
    .out_start_was_blocked(out_ch.start_was_blocked),
    .out_node_reached(out_ch.node_reached)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/bnr_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none
module bnr_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== hw/rtl/bnr_ctrl.sv =====
// walk sequencer state machine
`default_nettype none
module bnr_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire bnr_pkg::sts_t               sts,
  output bnr_pkg::cmd_t                    cmd
);
  typedef enum logic [11:0] {
    S_INIT = 12'b000000000001,
    S_IDLE = 12'b000000000010,
    S_QRY  = 12'b000000000100,
    S_CLR  = 12'b000000001000,
    S_SEED = 12'b000000010000,
    S_POP  = 12'b000000100000,
    S_ROWA = 12'b000001000000,
    S_ROWB = 12'b000010000000,
    S_ROWC = 12'b000100000000,
    S_EDGE = 12'b001000000000,
    S_ETGT = 12'b010000000000,
    S_ECHK = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;
  assign acc      = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init_sweep = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          cmd.accept = 1'b1;
          if (sts.run_ok) begin
            cmd.run_go = 1'b1;
            state_nxt  = S_CLR;
          end else if (sts.qry_ok) begin
            state_nxt = S_QRY;
          end else begin
            cmd.emit_imm = 1'b1;
          end
        end
      end
      S_QRY: begin
        cmd.emit_qry = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_CLR: begin
        cmd.run_sweep = 1'b1;
        if (sts.sweep_last) state_nxt = S_SEED;
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sts.q_empty) begin
          cmd.emit_run = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_ROWA;
        end
      end
      S_ROWA: begin
        cmd.row_lo = 1'b1;
        state_nxt  = S_ROWB;
      end
      S_ROWB: begin
        cmd.row_hi = 1'b1;
        state_nxt  = S_ROWC;
      end
      S_ROWC: begin
        cmd.row_end = 1'b1;
        state_nxt   = S_EDGE;
      end
      S_EDGE: begin
        if (sts.e_done) begin
          state_nxt = S_POP;
        end else begin
          cmd.edge_rd = 1'b1;
          state_nxt   = S_ETGT;
        end
      end
      S_ETGT: begin
        if (sts.t_ok) begin
          cmd.tgt_rd = 1'b1;
          state_nxt  = S_ECHK;
        end else begin
          state_nxt = S_EDGE;
        end
      end
      S_ECHK: begin
        cmd.visit = sts.t_free;
        state_nxt = S_EDGE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bnr_dp.sv =====
// graph tables, walk queue, counters and result register
`default_nettype none
module bnr_dp #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 8192
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bnr_pkg::cmd_t                 cmd,
  output bnr_pkg::sts_t                      sts,
  input  wire logic [bnr_pkg::NODE_W-1:0]    node_count,
  input  wire logic [bnr_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [bnr_pkg::IDX_W-1:0]     in_index,
  input  wire logic [bnr_pkg::VAL_W-1:0]     in_value,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [bnr_pkg::STAT_W-1:0]         out_status,
  output logic [bnr_pkg::NODE_W-1:0]         out_reached_count,
  output logic                               out_start_was_blocked,
  output logic                               out_node_reached
);
  localparam int RA_W = $clog2(MAX_NODES + 2);
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int BA_W = $clog2(MAX_NODES + 1);
  localparam int QA_W = $clog2(MAX_NODES);
  localparam int NW   = bnr_pkg::NODE_W;
  localparam int HW   = bnr_pkg::HI_W;

  logic [BA_W-1:0]              sweep_r;
  logic [NW-1:0]                start_r, cur_r, t_r, count_r, last_cnt_r;
  logic [bnr_pkg::VAL_W-1:0]    lo_r;
  logic [HW-1:0]                hi_r, e_r, hi_nxt;
  logic [QA_W:0]                head_r, tail_r;
  logic                         sblk_r, last_blk_r;
  logic                         out_valid_r, out_blk_r, out_rch_r;
  logic [bnr_pkg::STAT_W-1:0]   out_status_r, imm_status;
  logic [NW-1:0]                out_cnt_r;

  logic                         node_ok, q_push;
  logic [bnr_pkg::VAL_W-1:0]    row_rd;
  logic [NW-1:0]                edge_rd, q_rd;
  logic                         blk_rd, rch_rd;
  logic                         row_we, edge_we, blk_we, rch_we;
  logic [RA_W-1:0]              row_raddr;
  logic [BA_W-1:0]              blk_waddr, blk_raddr, rch_waddr, rch_raddr;
  logic                         blk_wdata;
  logic [QA_W-1:0]              q_waddr;
  logic [NW-1:0]                q_wdata;

  // item decode
  assign node_ok = (in_index != '0) && (32'(in_index) <= 32'(node_count));
  always_comb begin
    unique case (in_func)
      bnr_pkg::FN_ROW:   imm_status = (32'(in_index) > MAX_NODES + 1) ?
                                      bnr_pkg::ST_BAD_INDEX : bnr_pkg::ST_OK;
      bnr_pkg::FN_EDGE:  imm_status = (32'(in_index) >= MAX_EDGES) ?
                                      bnr_pkg::ST_BAD_INDEX : bnr_pkg::ST_OK;
      bnr_pkg::FN_BLK:   imm_status = (32'(in_index) > MAX_NODES) ?
                                      bnr_pkg::ST_BAD_INDEX : bnr_pkg::ST_OK;
      bnr_pkg::FN_RUN:   imm_status = node_ok ? bnr_pkg::ST_OK : bnr_pkg::ST_BAD_START;
      bnr_pkg::FN_QUERY: imm_status = node_ok ? bnr_pkg::ST_OK : bnr_pkg::ST_BAD_INDEX;
      default:           imm_status = bnr_pkg::ST_OK;
    endcase
  end

  // status toward the controller
  always_comb begin
    sts.sweep_last = (32'(sweep_r) == MAX_NODES);
    sts.run_ok     = (in_func == bnr_pkg::FN_RUN) && node_ok;
    sts.qry_ok     = (in_func == bnr_pkg::FN_QUERY) && node_ok;
    sts.q_empty    = (head_r == tail_r);
    sts.e_done     = (e_r >= hi_r);
    sts.t_ok       = (edge_rd != '0) && (edge_rd <= node_count);
    sts.t_free     = !blk_rd && !rch_rd;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // row start table
  assign row_we    = cmd.accept && (in_func == bnr_pkg::FN_ROW) &&
                     (imm_status == bnr_pkg::ST_OK);
  assign row_raddr = cmd.row_hi ? (RA_W'(cur_r) + RA_W'(1)) : RA_W'(q_rd);
  bnr_ram #(.W(bnr_pkg::VAL_W), .D(MAX_NODES + 2)) u_row (
    .clk, .we(row_we), .waddr(RA_W'(in_index)), .wdata(in_value),
    .raddr(row_raddr), .rdata(row_rd)
  );

  // edge target table
  assign edge_we = cmd.accept && (in_func == bnr_pkg::FN_EDGE) &&
                   (imm_status == bnr_pkg::ST_OK);
  bnr_ram #(.W(NW), .D(MAX_EDGES)) u_edge (
    .clk, .we(edge_we), .waddr(EA_W'(in_index)), .wdata(in_value[NW-1:0]),
    .raddr(EA_W'(e_r)), .rdata(edge_rd)
  );

  // blocked map, swept to zero after reset
  assign blk_we    = cmd.init_sweep || (cmd.accept && (in_func == bnr_pkg::FN_BLK) &&
                     (imm_status == bnr_pkg::ST_OK));
  assign blk_waddr = cmd.init_sweep ? sweep_r : BA_W'(in_index);
  assign blk_wdata = cmd.init_sweep ? 1'b0 : in_value[0];
  assign blk_raddr = cmd.tgt_rd ? BA_W'(edge_rd) : BA_W'(start_r);
  bnr_ram #(.W(1), .D(MAX_NODES + 1)) u_blk (
    .clk, .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
    .raddr(blk_raddr), .rdata(blk_rd)
  );

  // reached map, swept to zero after reset and at each run
  assign rch_we    = cmd.init_sweep || cmd.run_sweep || cmd.seed || cmd.visit;
  assign rch_waddr = (cmd.init_sweep || cmd.run_sweep) ? sweep_r :
                     (cmd.seed ? BA_W'(start_r) : BA_W'(t_r));
  assign rch_raddr = cmd.tgt_rd ? BA_W'(edge_rd) : BA_W'(in_index);
  bnr_ram #(.W(1), .D(MAX_NODES + 1)) u_rch (
    .clk, .we(rch_we), .waddr(rch_waddr), .wdata(cmd.seed || cmd.visit),
    .raddr(rch_raddr), .rdata(rch_rd)
  );

  // frontier queue
  assign q_push  = cmd.visit && (32'(tail_r) < MAX_NODES);
  assign q_waddr = cmd.seed ? '0 : tail_r[QA_W-1:0];
  assign q_wdata = cmd.seed ? start_r : t_r;
  bnr_ram #(.W(NW), .D(MAX_NODES)) u_queue (
    .clk, .we(cmd.seed || q_push), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head_r[QA_W-1:0]), .rdata(q_rd)
  );

  // row end clipped to the edge table
  assign hi_nxt = (32'(row_rd) > MAX_EDGES) ? HW'(MAX_EDGES) : HW'(row_rd);

  // walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      if (cmd.run_go) begin
        sweep_r <= '0;
      end else if ((cmd.init_sweep || cmd.run_sweep) && !sts.sweep_last) begin
        sweep_r <= sweep_r + BA_W'(1);
      end
      if (cmd.seed) begin
        head_r <= '0;
        tail_r <= (QA_W + 1)'(1);
      end else begin
        if (cmd.pop) head_r <= head_r + (QA_W + 1)'(1);
        if (q_push) tail_r <= tail_r + (QA_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_go) start_r <= NW'(in_index);
    if (cmd.seed) begin
      sblk_r  <= blk_rd;
      count_r <= NW'(1);
    end else if (cmd.visit) begin
      count_r <= count_r + NW'(1);
    end
    if (cmd.row_lo) cur_r <= q_rd;
    if (cmd.row_hi) lo_r <= row_rd;
    if (cmd.row_end) begin
      hi_r <= hi_nxt;
      e_r  <= HW'(lo_r);
    end else if (cmd.edge_rd) begin
      e_r <= e_r + HW'(1);
    end
    if (cmd.tgt_rd) t_r <= edge_rd;
  end

  // last run results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cnt_r <= '0;
      last_blk_r <= 1'b0;
    end else if (cmd.emit_run) begin
      last_cnt_r <= count_r;
      last_blk_r <= sblk_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_imm || cmd.emit_qry || cmd.emit_run) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_imm) begin
      out_status_r <= imm_status;
      out_cnt_r    <= last_cnt_r;
      out_blk_r    <= last_blk_r;
      out_rch_r    <= 1'b0;
    end else if (cmd.emit_qry) begin
      out_status_r <= bnr_pkg::ST_OK;
      out_cnt_r    <= last_cnt_r;
      out_blk_r    <= last_blk_r;
      out_rch_r    <= rch_rd;
    end else if (cmd.emit_run) begin
      out_status_r <= bnr_pkg::ST_OK;
      out_cnt_r    <= count_r;
      out_blk_r    <= sblk_r;
      out_rch_r    <= 1'b0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_reached_count     = out_cnt_r;
  assign out_start_was_blocked = out_blk_r;
  assign out_node_reached      = out_rch_r;
endmodule
`default_nettype wire

// ===== hw/rtl/bnr_checker.sv =====
// port-level checks for the reachability block, bound to the top level
`default_nettype none
module bnr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic        out_node_reached,
  input wire logic        cfg_pready
);
  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // a new item is only taken when the result slot frees
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!out_valid || out_ready))
    else $error("item taken while result slot is stuck");

  // reached flag only on a clean query result
  a_reach_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_node_reached) |-> (out_status == bnr_pkg::ST_OK))
    else $error("reached flag with error status");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("stalled result dropped or changed");

  // config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("config port stalled");
endmodule

bind blocked_node_reachability bnr_checker u_bnr_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
  .out_node_reached(out_ch.node_reached), .cfg_pready(cfg_pready)
);
`default_nettype wire
